// File: design/cba_pkg.sv
`default_nettype none

package cba_pkg;

  localparam int BLOCK_COUNT = 128;
  localparam int IDX_W = $clog2(BLOCK_COUNT);
  localparam int PTR_W = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2
  } op_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_en;
    logic wr_start_hit;
    logic wr_start_lo;
    logic wr_bit;
    logic wr_en;
    logic finish;
    logic finish_ok;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic shrink;
    logic zero_len;
    logic empty;
    logic clear_bad;
    logic grow_bad;
    logic hit;
    logic blocked;
    logic scan_end;
    logic wr_last;
  } status_t;

endpackage

`default_nettype wire

// File: design/cba_datapath.sv
`default_nettype none

module cba_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cba_pkg::cmd_t              cmd,
  output cba_pkg::status_t                status,
  input  wire logic [1:0]                 op,
  input  wire logic [cba_pkg::IDX_W-1:0]  run_start,
  input  wire logic [cba_pkg::IDX_W-1:0]  run_length,
  input  wire logic [cba_pkg::IDX_W-1:0]  target_length,
  output logic      [cba_pkg::IDX_W-1:0]  granted_start,
  output logic                            success
);

  // used bitmap: one-port memory plus per-entry valid bits
  logic                        mem [cba_pkg::BLOCK_COUNT];
  logic [cba_pkg::BLOCK_COUNT-1:0] vld;

  cba_pkg::op_t                op_q;
  logic                        shrink;
  logic [cba_pkg::IDX_W-1:0]   len;
  logic [cba_pkg::PTR_W-1:0]   lo;
  logic [cba_pkg::PTR_W-1:0]   hi;
  logic [cba_pkg::PTR_W-1:0]   cur;
  logic [cba_pkg::PTR_W-1:0]   eval_idx;
  logic [cba_pkg::IDX_W-1:0]   run;
  logic                        rd_vld;
  logic                        mem_q;
  logic                        vld_q;
  logic                        wbit;

  logic [cba_pkg::PTR_W-1:0]   lo_next;
  logic [cba_pkg::PTR_W-1:0]   hi_next;
  logic [cba_pkg::PTR_W-1:0]   start_w;
  logic [cba_pkg::PTR_W-1:0]   len_w;
  logic [cba_pkg::PTR_W-1:0]   tgt_w;
  logic [cba_pkg::PTR_W-1:0]   hi_m1;
  logic [cba_pkg::PTR_W-1:0]   hit_start;
  logic [cba_pkg::IDX_W-1:0]   run_inc;
  logic                        used_bit;

  assign start_w = cba_pkg::PTR_W'(run_start);
  assign len_w   = cba_pkg::PTR_W'(run_length);
  assign tgt_w   = cba_pkg::PTR_W'(target_length);

  always_comb begin
    lo_next = '0;
    hi_next = '0;
    unique case (op)
      cba_pkg::OP_ALLOC: begin
        lo_next = cba_pkg::PTR_W'(1);
        hi_next = cba_pkg::PTR_W'(cba_pkg::BLOCK_COUNT);
      end
      cba_pkg::OP_FREE: begin
        lo_next = start_w;
        hi_next = start_w + len_w;
      end
      cba_pkg::OP_RESIZE: begin
        if (target_length <= run_length) begin
          lo_next = start_w + tgt_w;
          hi_next = start_w + len_w;
        end else begin
          lo_next = start_w + len_w;
          hi_next = start_w + tgt_w;
        end
      end
      default: begin
        lo_next = '0;
        hi_next = '0;
      end
    endcase
  end

  // entry not yet written reads as its reset value
  assign used_bit  = vld_q ? mem_q : (eval_idx == '0);
  assign run_inc   = run + cba_pkg::IDX_W'(1);
  assign hi_m1     = hi - cba_pkg::PTR_W'(1);
  assign hit_start = eval_idx + cba_pkg::PTR_W'(1) - cba_pkg::PTR_W'(len);

  always_comb begin
    status.op        = op_q;
    status.shrink    = shrink;
    status.zero_len  = (len == '0);
    status.empty     = (hi <= lo);
    status.clear_bad = (lo == '0) || (hi > cba_pkg::PTR_W'(cba_pkg::BLOCK_COUNT));
    status.grow_bad  = (hi > cba_pkg::PTR_W'(cba_pkg::BLOCK_COUNT));
    status.hit       = rd_vld && !used_bit && (run_inc == len);
    status.blocked   = rd_vld && used_bit;
    status.scan_end  = rd_vld && (eval_idx == hi_m1);
    status.wr_last   = (cur == hi_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        rd_vld <= 1'b0;
      end else if (cmd.scan_en) begin
        rd_vld <= 1'b1;
      end
      if (cmd.wr_en) begin
        vld[cur[cba_pkg::IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cur[cba_pkg::IDX_W-1:0]] <= wbit;
    end
    mem_q <= mem[cur[cba_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[cur[cba_pkg::IDX_W-1:0]];
    if (cmd.load) begin
      op_q          <= cba_pkg::op_t'(op);
      shrink        <= (target_length <= run_length);
      len           <= run_length;
      lo            <= lo_next;
      hi            <= hi_next;
      granted_start <= '0;
    end
    if (cmd.wr_start_hit) begin
      cur <= hit_start;
    end else if (cmd.wr_start_lo || cmd.scan_start) begin
      cur <= lo;
    end else if (cmd.scan_en || cmd.wr_en) begin
      cur <= cur + cba_pkg::PTR_W'(1);
    end
    if (cmd.scan_start) begin
      run <= '0;
    end
    if (cmd.scan_en) begin
      eval_idx <= cur;
      if (rd_vld) begin
        run <= used_bit ? '0 : run_inc;
      end
    end
    if (cmd.wr_start_hit) begin
      hi            <= hit_start + cba_pkg::PTR_W'(len);
      granted_start <= hit_start[cba_pkg::IDX_W-1:0];
      wbit          <= 1'b1;
    end
    if (cmd.wr_start_lo) begin
      wbit <= cmd.wr_bit;
    end
    if (cmd.finish) begin
      success <= cmd.finish_ok;
    end
  end

endmodule

`default_nettype wire

// File: design/cba_ctrl.sv
`default_nettype none

module cba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output cba_pkg::cmd_t          cmd,
  input  wire cba_pkg::status_t  status
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (status.op)
          cba_pkg::OP_ALLOC: begin
            if (status.zero_len) begin
              cmd.finish    = 1'b1;
              cmd.finish_ok = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          cba_pkg::OP_FREE, cba_pkg::OP_RESIZE: begin
            if (status.op == cba_pkg::OP_RESIZE && !status.shrink) begin
              if (status.grow_bad) begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end else begin
              priority if (status.empty) begin
                cmd.finish    = 1'b1;
                cmd.finish_ok = 1'b1;
                state_next    = S_DONE;
              end else if (status.clear_bad) begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
              end else begin
                cmd.wr_start_lo = 1'b1;
                cmd.wr_bit      = 1'b0;
                state_next      = S_WRITE;
              end
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.op == cba_pkg::OP_ALLOC) begin
          priority if (status.hit) begin
            cmd.wr_start_hit = 1'b1;
            state_next       = S_WRITE;
          end else if (status.scan_end) begin
            cmd.finish = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end else begin
          priority if (status.blocked) begin
            cmd.finish = 1'b1;
            state_next = S_DONE;
          end else if (status.scan_end) begin
            cmd.wr_start_lo = 1'b1;
            cmd.wr_bit      = 1'b1;
            state_next      = S_WRITE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        if (status.wr_last) begin
          cmd.finish    = 1'b1;
          cmd.finish_ok = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/contiguous_block_allocator_core.sv
`default_nettype none

// First-fit allocator over a 128-block used bitmap (block 0 reserved). A request
// is taken when start is high and busy is low; busy stays high until the result
// beat, which appears on granted_start/success for exactly one cycle with done
// high and cannot be stalled, so the receiver must capture it then. The bitmap
// sits in a one-port memory touched one block per cycle. Allocate walks the map
// from block 1 until it finds a free run of len blocks, then marks that run used;
// a failed allocate walks the whole map. Free and shrink clear the released
// blocks; grow first checks that the added blocks are free, then marks them
// used. Rejected or empty requests finish right after the check. No clearing
// pass is needed at reset.
module contiguous_block_allocator_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 op,
  input  wire logic [cba_pkg::IDX_W-1:0]  run_start,
  input  wire logic [cba_pkg::IDX_W-1:0]  run_length,
  input  wire logic [cba_pkg::IDX_W-1:0]  target_length,
  output logic                            done,
  output logic      [cba_pkg::IDX_W-1:0]  granted_start,
  output logic                            success
);

  cba_pkg::cmd_t    cmd;
  cba_pkg::status_t status;

  cba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  cba_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .op            (op),
    .run_start     (run_start),
    .run_length    (run_length),
    .target_length (target_length),
    .granted_start (granted_start),
    .success       (success)
  );

  // a request moves the block out of idle
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted request did not raise busy");

  // result beat is followed by idle
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after result beat");

  // a nonzero start is only granted on success
  a_grant_ok : assert property (@(posedge clk) disable iff (rst)
    done && (granted_start != '0) |-> success)
    else $error("nonzero start on failed request");

  // result beat only while a request is open
  a_one_result : assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat outside a request");

endmodule

`default_nettype wire
